@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PFE_ASSERT_NOW(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PFE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

@@ design/pfe_pkg.sv @@
// Types and constants of the protocol-buffer field extractor.
`default_nettype none

package pfe_pkg;

  // Stream and configuration widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 72;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_LIMIT = 1'd1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NAME = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TEXT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  // End-record status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_WIRE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MID      = 2'd2;

  // Wire types
  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_FIX64  = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_FIX32  = 3'd5;

  // Field numbers
  localparam logic [31:0] FIELD_SUB_NAME = 32'd1;
  localparam logic [31:0] FIELD_TIME     = 32'd2;
  localparam logic [31:0] FIELD_SUBMSG   = 32'd3;
  localparam logic [31:0] FIELD_TEXT     = 32'd5;

  // What a pending length prefix belongs to
  localparam logic [1:0] LEN_SKIP   = 2'd0;
  localparam logic [1:0] LEN_NESTED = 2'd1;
  localparam logic [1:0] LEN_TEXT   = 2'd2;
  localparam logic [1:0] LEN_NAME   = 2'd3;

  // Varint group count saturates here (shift of 70 bits)
  localparam logic [3:0] VAR_GROUPS_MAX = 4'd10;

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [63:0]         value;
    logic                first_byte;
    logic [STATUS_W-1:0] status;
    logic                run_last;
  } pfe_result_t;

endpackage

`default_nettype wire

@@ design/protobuf_field_extractor.sv @@
// Top level of the streaming protocol-buffer field extractor.
// Usage:
//   The slave stream carries one message byte per transfer in s_tdata_i[7:0],
//   with s_tlast_i high on the final byte of a message. The master stream
//   carries result items: m_tuser_o is the kind (short-name byte, text byte,
//   end record), m_tdata_o holds value, first_byte and status, and m_tlast_o
//   marks the last result caused by one input byte.
//   The configuration port writes name_limit (index 0) and text_limit
//   (index 1); the user writes them only while the block is idle, which the block does not enforce.
// Timing:
//   Each accepted byte is decoded in the cycle of its transfer; its results
//   enter a registered four-entry result queue and reach the master side
//   behind waiting results. One byte is accepted per cycle while s_tready_o
//   is high. A byte that yields two results (string byte plus end record)
//   takes two master-side transfers. s_tready_o is high while at most two
//   results wait. With the receiver stalled, input stops once three or more wait.
// Reset:
//   Parse state clears to "expect a top-level key"; limits return to 31 and
//   255; the result queue empties. After each end record the parse state
//   returns to its reset values, the limits are kept.
`default_nettype none

module protobuf_field_extractor #(
  parameter int LEN_BITS = 32,
  parameter int MAX_STR  = 255
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_tvalid_i,
  output logic                                  s_tready_o,
  input  wire logic [pfe_pkg::IN_DATA_W-1:0]    s_tdata_i,   // [7:0] byte_value
  input  wire logic                             s_tlast_i,   // last_byte
  output logic                                  m_tvalid_o,
  input  wire logic                             m_tready_i,
  output logic [pfe_pkg::OUT_DATA_W-1:0]        m_tdata_o,   // [63:0] value, [64] first_byte,
                                                             // [66:65] status, rest zero
  output logic [pfe_pkg::KIND_W-1:0]            m_tuser_o,   // [1:0] kind
  output logic                                  m_tlast_o,   // run_last
  input  wire logic                             cfg_we_i,
  input  wire logic [pfe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pfe_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import pfe_pkg::*;

  localparam int CNT_W = $clog2(MAX_STR + 1);
  localparam logic [63:0] LEN_MASK = (64'd1 << LEN_BITS) - 64'd1;
  localparam logic [7:0]  MAX_STR_C = 8'(MAX_STR);

  // Parse modes
  localparam logic [3:0] M_KEY       = 4'd0;
  localparam logic [3:0] M_TIME      = 4'd1;
  localparam logic [3:0] M_SKIPVAR   = 4'd2;
  localparam logic [3:0] M_LEN       = 4'd3;
  localparam logic [3:0] M_SKIPBYTES = 4'd4;
  localparam logic [3:0] M_NAME      = 4'd5;
  localparam logic [3:0] M_TEXT      = 4'd6;
  localparam logic [3:0] M_SKIPREST  = 4'd7;
  localparam logic [3:0] M_HALT      = 4'd8;

  // Configuration registers
  logic [7:0] name_limit_q, text_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_limit_q <= 8'd31;
      text_limit_q <= 8'd255;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_NAME_LIMIT) begin
        name_limit_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_TEXT_LIMIT) begin
        text_limit_q <= cfg_data_i;
      end
    end
  end

  // Parse state
  logic [3:0]          mode_q, mode_d;
  logic [63:0]         acc_q, acc_d;
  logic [3:0]          groups_q, groups_d;
  logic [1:0]          len_kind_q, len_kind_d;
  logic [LEN_BITS-1:0] bytes_left_q, bytes_left_d;
  logic [LEN_BITS-1:0] nested_left_q, nested_left_d;
  logic                nested_q, nested_d;
  logic [63:0]         time_q, time_d;
  logic [CNT_W-1:0]    copied_q, copied_d;
  logic                halted_q, halted_d;

  logic                in_xfer;
  logic [7:0]          in_byte;
  logic [63:0]         acc_take;
  logic [3:0]          groups_take;
  logic                var_done;
  logic [31:0]         key_field;
  logic [2:0]          key_wire;
  logic [LEN_BITS-1:0] len_sat;
  logic [7:0]          lim;
  logic                is_name;
  logic [LEN_BITS-1:0] bytes_dec;
  pfe_result_t         res0, res1;
  logic                res0_v, res1_v;

  assign in_xfer = s_tvalid_i && s_tready_o;
  assign in_byte = s_tdata_i[7:0];

  // Varint byte intake: payload bits past bit 63 are dropped
  always_comb begin
    acc_take = acc_q;
    if (groups_q < 4'd10) begin
      acc_take = acc_q | (64'(in_byte[6:0]) << (7'(groups_q) * 7'd7));
    end
    var_done    = !in_byte[7];
    groups_take = groups_q;
    if (in_byte[7] && groups_q < VAR_GROUPS_MAX) begin
      groups_take = groups_q + 4'd1;
    end
  end

  assign key_field = acc_take[34:3];
  assign key_wire  = acc_take[2:0];
  assign len_sat   = (acc_take > LEN_MASK) ? LEN_MASK[LEN_BITS-1:0]
                                           : acc_take[LEN_BITS-1:0];
  assign is_name   = (mode_q == M_NAME);
  assign bytes_dec = (bytes_left_q != '0) ? bytes_left_q - 1'b1 : bytes_left_q;

  always_comb begin
    if (is_name) begin
      lim = (name_limit_q > MAX_STR_C) ? MAX_STR_C : name_limit_q;
    end else begin
      lim = (text_limit_q > MAX_STR_C) ? MAX_STR_C : text_limit_q;
    end
  end

  // Next parse state and results for one byte
  always_comb begin
    mode_d        = mode_q;
    acc_d         = acc_q;
    groups_d      = groups_q;
    len_kind_d    = len_kind_q;
    bytes_left_d  = bytes_left_q;
    nested_left_d = nested_left_q;
    nested_d      = nested_q;
    time_d        = time_q;
    copied_d      = copied_q;
    halted_d      = halted_q;
    res0_v        = 1'b0;
    res1_v        = 1'b0;
    res0          = '0;
    res1          = '0;

    // submessage byte budget
    if (mode_q != M_HALT && nested_q && nested_left_q != '0) begin
      nested_left_d = nested_left_q - 1'b1;
    end

    case (mode_q)
      M_KEY: begin
        acc_d    = acc_take;
        groups_d = groups_take;
        if (var_done) begin
          acc_d    = '0;
          groups_d = '0;
          if (nested_q && key_field == FIELD_SUB_NAME && key_wire == WIRE_LEN) begin
            mode_d     = M_LEN;
            len_kind_d = LEN_NAME;
          end else if (!nested_q && key_field == FIELD_TIME && key_wire == WIRE_VARINT) begin
            mode_d = M_TIME;
          end else if (!nested_q && key_field == FIELD_SUBMSG && key_wire == WIRE_LEN) begin
            mode_d     = M_LEN;
            len_kind_d = LEN_NESTED;
          end else if (!nested_q && key_field == FIELD_TEXT && key_wire == WIRE_LEN) begin
            mode_d     = M_LEN;
            len_kind_d = LEN_TEXT;
          end else begin
            // skip by wire type
            case (key_wire)
              WIRE_VARINT: mode_d = M_SKIPVAR;
              WIRE_LEN: begin
                mode_d     = M_LEN;
                len_kind_d = LEN_SKIP;
              end
              WIRE_FIX64: begin
                mode_d       = M_SKIPBYTES;
                bytes_left_d = LEN_BITS'(8);
              end
              WIRE_FIX32: begin
                mode_d       = M_SKIPBYTES;
                bytes_left_d = LEN_BITS'(4);
              end
              default: begin
                mode_d   = M_HALT;
                halted_d = 1'b1;
              end
            endcase
          end
        end
      end
      M_TIME: begin
        acc_d    = acc_take;
        groups_d = groups_take;
        if (var_done) begin
          time_d   = acc_take;
          acc_d    = '0;
          groups_d = '0;
          mode_d   = M_KEY;
        end
      end
      M_SKIPVAR: begin
        acc_d    = acc_take;
        groups_d = groups_take;
        if (var_done) begin
          acc_d    = '0;
          groups_d = '0;
          mode_d   = M_KEY;
        end
      end
      M_LEN: begin
        acc_d    = acc_take;
        groups_d = groups_take;
        if (var_done) begin
          acc_d    = '0;
          groups_d = '0;
          case (len_kind_q)
            LEN_NESTED: begin
              nested_d      = 1'b1;
              nested_left_d = len_sat;
              mode_d        = M_KEY;
            end
            LEN_TEXT: begin
              bytes_left_d = len_sat;
              copied_d     = '0;
              mode_d       = (len_sat != '0) ? M_TEXT : M_KEY;
            end
            LEN_NAME: begin
              bytes_left_d = len_sat;
              copied_d     = '0;
              mode_d       = (len_sat != '0) ? M_NAME : M_SKIPREST;
            end
            default: begin
              bytes_left_d = len_sat;
              mode_d       = (len_sat != '0) ? M_SKIPBYTES : M_KEY;
            end
          endcase
        end
      end
      M_SKIPBYTES: begin
        bytes_left_d = bytes_dec;
        if (bytes_dec == '0) begin
          mode_d = M_KEY;
        end
      end
      M_NAME, M_TEXT: begin
        if (8'(copied_q) < lim) begin
          res0_v          = 1'b1;
          res0.kind       = is_name ? KIND_NAME : KIND_TEXT;
          res0.value      = 64'(in_byte);
          res0.first_byte = (copied_q == '0);
          copied_d        = copied_q + 1'b1;
        end
        bytes_left_d = bytes_dec;
        if (bytes_dec == '0) begin
          mode_d = is_name ? M_SKIPREST : M_KEY;
        end
      end
      M_SKIPREST, M_HALT: begin
        mode_d = mode_q;
      end
      default: mode_d = M_HALT;
    endcase

    // submessage end cuts off any open field
    if (mode_d != M_HALT && nested_d && nested_left_d == '0) begin
      nested_d     = 1'b0;
      bytes_left_d = '0;
      acc_d        = '0;
      groups_d     = '0;
      mode_d       = M_KEY;
    end

    // end record and restart for the next message
    if (s_tlast_i) begin
      res1_v     = 1'b1;
      res1.kind  = KIND_END;
      res1.value = time_d;
      if (halted_d) begin
        res1.status = STATUS_BAD_WIRE;
      end else if (mode_d != M_KEY || nested_d || groups_d != '0) begin
        res1.status = STATUS_MID;
      end else begin
        res1.status = STATUS_OK;
      end
      mode_d        = M_KEY;
      acc_d         = '0;
      groups_d      = '0;
      len_kind_d    = LEN_SKIP;
      bytes_left_d  = '0;
      nested_left_d = '0;
      nested_d      = 1'b0;
      time_d        = '0;
      copied_d      = '0;
      halted_d      = 1'b0;
    end

    res0.run_last = !res1_v;
    res1.run_last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= M_KEY;
      acc_q         <= '0;
      groups_q      <= '0;
      len_kind_q    <= LEN_SKIP;
      bytes_left_q  <= '0;
      nested_left_q <= '0;
      nested_q      <= 1'b0;
      time_q        <= '0;
      copied_q      <= '0;
      halted_q      <= 1'b0;
    end else if (in_xfer) begin
      mode_q        <= mode_d;
      acc_q         <= acc_d;
      groups_q      <= groups_d;
      len_kind_q    <= len_kind_d;
      bytes_left_q  <= bytes_left_d;
      nested_left_q <= nested_left_d;
      nested_q      <= nested_d;
      time_q        <= time_d;
      copied_q      <= copied_d;
      halted_q      <= halted_d;
    end
  end

  // Result queue: four entries, up to two pushed per transfer
  pfe_result_t fifo_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  count_q;
  logic        pop;
  logic [1:0]  push_n;
  pfe_result_t push_first;

  assign s_tready_o = (count_q <= 3'd2);
  assign m_tvalid_o = (count_q != 3'd0);
  assign pop        = m_tvalid_o && m_tready_i;
  assign push_n     = in_xfer ? (2'(res0_v) + 2'(res1_v)) : 2'd0;
  assign push_first = res0_v ? res0 : res1;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= push_first;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_n;
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + 3'(push_n) - 3'(pop);
    end
  end

  // Master-side packing
  assign m_tuser_o = fifo_q[rd_ptr_q].kind;
  assign m_tlast_o = fifo_q[rd_ptr_q].run_last;
  assign m_tdata_o = {5'd0, fifo_q[rd_ptr_q].status, fifo_q[rd_ptr_q].first_byte,
                      fifo_q[rd_ptr_q].value};

endmodule

`default_nettype wire

@@ design/pfe_checker.sv @@
// Port-level checker for the protobuf field extractor, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module pfe_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_tvalid_i,
  input wire logic                             s_tready_o,
  input wire logic                             s_tlast_i,
  input wire logic                             m_tvalid_o,
  input wire logic                             m_tready_i,
  input wire logic [pfe_pkg::OUT_DATA_W-1:0]   m_tdata_o,
  input wire logic [pfe_pkg::KIND_W-1:0]       m_tuser_o,
  input wire logic                             m_tlast_o
);
  import pfe_pkg::*;

  logic is_end;
  logic is_string;
  logic string_clean;
  logic last_in;
  logic m_stall;
  assign is_end       = m_tvalid_o && (m_tuser_o == KIND_END);
  assign is_string    = m_tvalid_o && (m_tuser_o == KIND_NAME || m_tuser_o == KIND_TEXT);
  assign string_clean = (m_tdata_o[63:8] == '0) && (m_tdata_o[66:65] == STATUS_OK);
  assign last_in      = s_tvalid_i && s_tready_o && s_tlast_i;
  assign m_stall      = m_tvalid_o && !m_tready_i;

  // An end record is always the last result of its byte
  `PFE_ASSERT_NOW(a_end_is_run_last, clk_i, rst_ni, is_end, m_tlast_o)

  // An end record carries no first-byte flag
  `PFE_ASSERT_NOW(a_end_no_first, clk_i, rst_ni, is_end, !m_tdata_o[64])

  // String bytes carry ok status and a value of one byte
  `PFE_ASSERT_NOW(a_string_clean, clk_i, rst_ni, is_string, string_clean)

  // The final byte of a message always leaves a result offered
  `PFE_ASSERT_NEXT(a_last_gives_end, clk_i, rst_ni, last_in, m_tvalid_o)

  // A stalled result stays offered unchanged
  `PFE_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, m_stall, m_tvalid_o && $stable(m_tdata_o))

endmodule

bind protobuf_field_extractor pfe_checker u_pfe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_tvalid_i),
  .s_tready_o (s_tready_o),
  .s_tlast_i  (s_tlast_i),
  .m_tvalid_o (m_tvalid_o),
  .m_tready_i (m_tready_i),
  .m_tdata_o  (m_tdata_o),
  .m_tuser_o  (m_tuser_o),
  .m_tlast_o  (m_tlast_o)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the protocol-buffer field extractor stream block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfe_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 250;
  localparam int HOLD_AT_BYTE = 420;
  localparam int PRINT_CAP    = 50;

  // Wire types that the block refuses
  localparam logic [2:0] WIRE_SGROUP = 3'd3;
  localparam logic [2:0] WIRE_EGROUP = 3'd4;
  localparam logic [2:0] WIRE_RSVD6  = 3'd6;
  localparam logic [2:0] WIRE_RSVD7  = 3'd7;

  typedef enum logic [3:0] {
    PM_KEY, PM_TIME, PM_SKIPVAR, PM_LEN, PM_SKIPBYTES,
    PM_NAME, PM_TEXT, PM_SKIPREST, PM_HALT
  } parse_mode_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  // DUT connections; the driven inputs are known from time zero
  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  logic [IN_DATA_W-1:0]    s_tdata   = '0;
  logic                    s_tlast   = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0]   m_tdata;
  logic [KIND_W-1:0]       m_tuser;
  logic                    m_tlast;
  logic                    cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;

  protobuf_field_extractor u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tlast_i   (s_tlast),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .m_tuser_o   (m_tuser),
    .m_tlast_o   (m_tlast),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Byte stream waiting for the driver, and results the parser owes us
  msg_byte_t   byte_q[$];
  pfe_result_t due_results[$];

  // Shadow of the parser state and limits
  logic [7:0]  name_lim = 8'd31;
  logic [7:0]  text_lim = 8'd255;
  parse_mode_e pmode;
  logic [63:0] acc;
  int          vshift;
  logic [31:0] fld;
  logic [2:0]  wtype;
  logic [31:0] left_cnt;
  logic [31:0] sub_left;
  logic        in_sub;
  logic [63:0] tval;
  logic [7:0]  copied;
  logic        halted;

  // Bookkeeping
  int  err_cnt   = 0;
  int  res_cnt   = 0;
  int  bytes_in  = 0;
  int  msg_cnt   = 0;
  int  kind_cnt[3];
  int  status_cnt[3];
  bit  quiet     = 1'b0;
  bit  hold_done = 1'b0;
  int  send_gap  = 0;
  int  recv_gap  = 0;
  int  hold_left = 0;
  int  stall_cycles = 0;

  // Message under construction; into_sub diverts bytes to the submessage body
  logic [7:0] msg[$];
  logic [7:0] sub_body[$];
  bit         into_sub = 1'b0;

  // ---------------------------------------------------------------------------
  // Parser shadow
  // ---------------------------------------------------------------------------
  task automatic clear_parse();
    pmode    = PM_KEY;
    acc      = '0;
    vshift   = 0;
    fld      = '0;
    wtype    = '0;
    left_cnt = '0;
    sub_left = '0;
    in_sub   = 1'b0;
    tval     = '0;
    copied   = '0;
    halted   = 1'b0;
  endtask

  // One 7-bit group; true when the varint is complete
  function automatic logic take_group(input logic [7:0] b);
    if (vshift < 64) acc |= 64'(b[6:0]) << vshift;
    if (b[7]) begin
      if (vshift < 70) vshift += 7;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic begin_skip(input logic [2:0] w);
    case (w)
      WIRE_VARINT: pmode = PM_SKIPVAR;
      WIRE_LEN:    pmode = PM_LEN;
      WIRE_FIX64: begin
        left_cnt = 32'd8;
        pmode    = PM_SKIPBYTES;
      end
      WIRE_FIX32: begin
        left_cnt = 32'd4;
        pmode    = PM_SKIPBYTES;
      end
      default: begin
        pmode  = PM_HALT;
        halted = 1'b1;
      end
    endcase
  endtask

  // Advance the shadow by one accepted byte and queue what it must produce
  task automatic parse_byte(input logic [7:0] b, input logic last);
    pfe_result_t outs[2];
    int          n;
    logic [31:0] len;
    logic [7:0]  lim;
    logic        is_name;
    n = 0;
    if (pmode != PM_HALT && in_sub && sub_left != 0) sub_left--;
    case (pmode)
      PM_KEY: if (take_group(b)) begin
        fld    = acc[34:3];
        wtype  = acc[2:0];
        acc    = '0;
        vshift = 0;
        if (in_sub) begin
          if (fld == FIELD_SUB_NAME && wtype == WIRE_LEN) pmode = PM_LEN;
          else begin_skip(wtype);
        end else if (fld == FIELD_TIME && wtype == WIRE_VARINT) begin
          pmode = PM_TIME;
        end else if ((fld == FIELD_SUBMSG || fld == FIELD_TEXT) && wtype == WIRE_LEN) begin
          pmode = PM_LEN;
        end else begin
          begin_skip(wtype);
        end
      end
      PM_TIME: if (take_group(b)) begin
        tval   = acc;
        acc    = '0;
        vshift = 0;
        pmode  = PM_KEY;
      end
      PM_SKIPVAR: if (take_group(b)) begin
        acc    = '0;
        vshift = 0;
        pmode  = PM_KEY;
      end
      PM_LEN: if (take_group(b)) begin
        len    = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
        acc    = '0;
        vshift = 0;
        if (!in_sub && fld == FIELD_SUBMSG && wtype == WIRE_LEN) begin
          in_sub   = 1'b1;
          sub_left = len;
          pmode    = PM_KEY;
        end else if (!in_sub && fld == FIELD_TEXT && wtype == WIRE_LEN) begin
          left_cnt = len;
          copied   = '0;
          pmode    = (len != 0) ? PM_TEXT : PM_KEY;
        end else if (in_sub && fld == FIELD_SUB_NAME && wtype == WIRE_LEN) begin
          left_cnt = len;
          copied   = '0;
          pmode    = (len != 0) ? PM_NAME : PM_SKIPREST;
        end else begin
          left_cnt = len;
          pmode    = (len != 0) ? PM_SKIPBYTES : PM_KEY;
        end
      end
      PM_SKIPBYTES: begin
        if (left_cnt != 0) left_cnt--;
        if (left_cnt == 0) pmode = PM_KEY;
      end
      PM_NAME, PM_TEXT: begin
        // 8-bit limits never exceed the string clamp of 255
        is_name = (pmode == PM_NAME);
        lim     = is_name ? name_lim : text_lim;
        if (copied < lim) begin
          outs[n] = '{kind: is_name ? KIND_NAME : KIND_TEXT, value: 64'(b),
                      first_byte: (copied == 0), status: STATUS_OK, run_last: 1'b0};
          n++;
          copied++;
        end
        if (left_cnt != 0) left_cnt--;
        if (left_cnt == 0) pmode = is_name ? PM_SKIPREST : PM_KEY;
      end
      PM_SKIPREST: ;
      default: pmode = PM_HALT;
    endcase

    // Submessage boundary cuts off whatever is open inside it
    if (pmode != PM_HALT && in_sub && sub_left == 0) begin
      in_sub   = 1'b0;
      left_cnt = '0;
      acc      = '0;
      vshift   = 0;
      pmode    = PM_KEY;
    end

    if (last) begin
      outs[n] = '{kind: KIND_END, value: tval, first_byte: 1'b0, run_last: 1'b0,
                  status: halted ? STATUS_BAD_WIRE :
                          (pmode != PM_KEY || in_sub || vshift != 0) ? STATUS_MID :
                          STATUS_OK};
      n++;
      clear_parse();
    end

    if (n > 0) outs[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) due_results.push_back(outs[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Message construction
  // ---------------------------------------------------------------------------
  task automatic add_byte(input logic [7:0] b);
    if (into_sub) sub_body.push_back(b);
    else msg.push_back(b);
  endtask

  task automatic add_varint(input logic [63:0] v);
    while (v > 64'd127) begin
      add_byte({1'b1, v[6:0]});
      v = v >> 7;
    end
    add_byte({1'b0, v[6:0]});
  endtask

  task automatic add_key(input logic [63:0] f, input logic [2:0] w);
    add_varint({f[60:0], w});
  endtask

  task automatic add_junk(input int n);
    repeat (n) add_byte(8'($urandom));
  endtask

  task automatic add_string(input logic [63:0] f, input int len);
    add_key(f, WIRE_LEN);
    add_varint(64'(len));
    add_junk(len);
  endtask

  task automatic add_string_body(input int len);
    add_varint(64'(len));
    add_junk(len);
  endtask

  task automatic open_sub();
    sub_body.delete();
    into_sub = 1'b1;
  endtask

  // Emit the submessage with its length off by delta (0 for well-formed)
  task automatic close_sub(input int delta);
    int len;
    into_sub = 1'b0;
    len = sub_body.size() + delta;
    if (len < 0) len = 0;
    add_key(64'(FIELD_SUBMSG), WIRE_LEN);
    add_varint(64'(len));
    foreach (sub_body[i]) add_byte(sub_body[i]);
  endtask

  function automatic logic [63:0] pick_field();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 64'($urandom_range(0, 20));
    if (r < 92) return 64'($urandom);
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_value();
    int          w;
    logic [63:0] v;
    w = $urandom_range(0, 64);
    v = {$urandom, $urandom};
    if (w < 64) v &= (64'd1 << w) - 64'd1;
    return v;
  endfunction

  function automatic logic [2:0] bad_wire();
    case ($urandom_range(0, 3))
      0:       return WIRE_SGROUP;
      1:       return WIRE_EGROUP;
      2:       return WIRE_RSVD6;
      default: return WIRE_RSVD7;
    endcase
  endfunction

  // A field the parser has to skip by its wire type
  task automatic add_skip_field();
    logic [2:0] w;
    case ($urandom_range(0, 3))
      0:       w = WIRE_VARINT;
      1:       w = WIRE_FIX64;
      2:       w = WIRE_LEN;
      default: w = WIRE_FIX32;
    endcase
    add_key(pick_field(), w);
    case (w)
      WIRE_VARINT:
        if ($urandom_range(0, 19) == 0) begin
          // overlong varint: shift saturates
          repeat ($urandom_range(10, 13)) add_byte(8'h80 | 8'($urandom));
          add_byte(8'($urandom) & 8'h7F);
        end else begin
          add_varint(rand_value());
        end
      WIRE_FIX64: add_junk(8);
      WIRE_FIX32: add_junk(4);
      default:
        if ($urandom_range(0, 32) == 0) begin
          // length beyond 32 bits saturates; message ends inside it
          add_varint({$urandom, $urandom} | 64'h1_0000_0000);
          add_junk(2);
        end else begin
          add_string_body($urandom_range(0, 6));
        end
    endcase
  endtask

  task automatic build_sub();
    int r;
    int delta;
    open_sub();
    repeat ($urandom_range(0, 3)) begin
      r = $urandom_range(0, 19);
      if (r < 10) add_string(64'(FIELD_SUB_NAME), ($urandom_range(0, 30) == 0) ?
                             $urandom_range(30, 60) : $urandom_range(0, 7));
      else if (r < 19) add_skip_field();
      else add_key(pick_field(), bad_wire());
    end
    delta = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 6)) - 3 : 0;
    close_sub(delta);
  endtask

  task automatic build_random_msg();
    int r;
    int keep;
    msg.delete();
    repeat ($urandom_range(1, 6)) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        add_key(64'(FIELD_TIME), WIRE_VARINT);
        add_varint(rand_value());
      end else if (r < 35) begin
        add_string(64'(FIELD_TEXT), ($urandom_range(0, 49) == 0) ?
                   $urandom_range(200, 300) : $urandom_range(0, 8));
      end else if (r < 60) begin
        build_sub();
      end else if (r < 87) begin
        add_skip_field();
      end else if (r < 89) begin
        add_key(pick_field(), bad_wire());
        add_junk($urandom_range(0, 3));
      end else begin
        add_junk($urandom_range(1, 4));
      end
    end
    // some messages are cut short anywhere
    if ($urandom_range(0, 11) == 0) begin
      keep = $urandom_range(1, msg.size());
      while (msg.size() > keep) void'(msg.pop_back());
    end
  endtask

  task automatic send_msg();
    @(negedge clk);
    foreach (msg[i]) byte_q.push_back('{data: msg[i], last: (i == msg.size() - 1)});
    msg_cnt++;
  endtask

  task automatic run_random(input int nbytes);
    int sent;
    sent = 0;
    while (sent < nbytes) begin
      build_random_msg();
      sent += msg.size();
      send_msg();
    end
  endtask

  // Wait until everything is sent and every result is back, then let the block settle
  task automatic wait_idle();
    @(negedge clk);
    while (byte_q.size() != 0 || s_tvalid || due_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limits(input logic [7:0] nl, input logic [7:0] tl);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NAME_LIMIT;
    cfg_data  <= nl;
    @(posedge clk);
    cfg_index <= CFG_TEXT_LIMIT;
    cfg_data  <= tl;
    @(posedge clk);
    cfg_we    <= 1'b0;
    name_lim = nl;
    text_lim = tl;
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_cnt++;
    if (err_cnt <= PRINT_CAP)
      $display("%0t: result %0d: %s got 0x%0h, want 0x%0h", $time, res_cnt, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, predicts each on transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_byte(byte_q[0].data, byte_q[0].last);
        void'(byte_q.pop_front());
        bytes_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= byte_q[0].data;
          s_tlast  <= byte_q[0].last;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus one long hold-off while input keeps coming
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_tready <= 1'b0;
      recv_gap = 0;
      hold_left = 0;
    end else begin
      if (!hold_done && bytes_in >= HOLD_AT_BYTE) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // Monitor: each result transfer against the oldest owed result
  always @(posedge clk) begin
    pfe_result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result, value", m_tdata[63:0], '0);
      end else begin
        want = due_results.pop_front();
        if (m_tuser !== want.kind)
          report_mismatch("kind", 64'(m_tuser), 64'(want.kind));
        if (m_tdata[63:0] !== want.value)
          report_mismatch("value", m_tdata[63:0], want.value);
        if (m_tdata[64] !== want.first_byte)
          report_mismatch("first_byte", 64'(m_tdata[64]), 64'(want.first_byte));
        if (m_tdata[66:65] !== want.status)
          report_mismatch("status", 64'(m_tdata[66:65]), 64'(want.status));
        if (m_tlast !== want.run_last)
          report_mismatch("run_last", 64'(m_tlast), 64'(want.run_last));
        if (m_tdata[OUT_DATA_W-1:67] !== '0)
          report_mismatch("padding", 64'(m_tdata[OUT_DATA_W-1:67]), '0);
        kind_cnt[want.kind]++;
        if (want.kind == KIND_END) status_cnt[want.status]++;
      end
      res_cnt++;
    end
  end

  // Watchdog: too long without any transfer on either stream
  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, due_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    clear_parse();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed messages at the reset limits
    msg.delete();
    add_key(64'(FIELD_TIME), WIRE_VARINT);
    add_varint('1);
    add_key(64'(FIELD_TEXT), WIRE_LEN);
    add_varint(64'd2);
    add_byte(8'h00);
    add_byte(8'hFF);
    send_msg();

    // name streamed, second name in the same submessage dropped, empty text, fixed skips
    msg.delete();
    open_sub();
    add_string(64'(FIELD_SUB_NAME), 3);
    add_string(64'(FIELD_SUB_NAME), 1);
    close_sub(0);
    add_key(64'(FIELD_TEXT), WIRE_LEN);
    add_varint(64'd0);
    add_key(64'd9, WIRE_FIX32);
    add_junk(4);
    add_key(64'd9, WIRE_FIX64);
    add_junk(8);
    send_msg();

    // bad wire type halts the parse
    msg.delete();
    add_key(64'(FIELD_SUB_NAME), WIRE_EGROUP);
    add_byte(8'hFF);
    add_byte(8'h80);
    send_msg();

    // ends inside a text string: string byte and end record from one input byte
    msg.delete();
    add_key(64'(FIELD_TEXT), WIRE_LEN);
    add_varint(64'd4);
    add_junk(2);
    send_msg();

    // submessage ends with its name still open; field number aliasing onto time
    msg.delete();
    open_sub();
    add_key(64'(FIELD_SUB_NAME), WIRE_LEN);
    add_varint(64'd5);
    close_sub(0);
    add_key(64'h1_0000_0002, WIRE_VARINT);
    add_varint(64'd5);
    send_msg();

    // overlong time varint, then a length that saturates
    msg.delete();
    add_key(64'(FIELD_TIME), WIRE_VARINT);
    repeat (11) add_byte(8'hFF);
    add_byte(8'h01);
    add_key(64'd7, WIRE_LEN);
    add_varint(64'h0000_0100_0000_0000);
    add_junk(1);
    send_msg();

    // empty name, later name ignored, message ends on a lone zero key
    msg.delete();
    open_sub();
    add_string(64'(FIELD_SUB_NAME), 0);
    add_string(64'(FIELD_SUB_NAME), 2);
    close_sub(0);
    add_byte(8'h00);
    send_msg();
    wait_idle();

    // Both limits zero: strings consumed, nothing streamed
    write_limits(8'd0, 8'd0);
    run_random(200);
    wait_idle();

    // Largest limits, no idling; one text longer than the limit
    write_limits(8'd255, 8'd255);
    quiet = 1'b1;
    msg.delete();
    add_string(64'(FIELD_TEXT), 260);
    send_msg();
    run_random(150);
    wait_idle();
    quiet = 1'b0;

    // One-byte limits
    write_limits(8'd1, 8'd1);
    run_random(200);
    wait_idle();

    // Random limits: small name limit, text limit over its full range
    write_limits(8'($urandom_range(2, 20)), 8'($urandom_range(0, 255)));
    run_random(300);
    wait_idle();
    repeat (8) @(posedge clk);

    $display("Covered %0d messages, %0d bytes in, %0d results checked", msg_cnt, bytes_in,
             res_cnt);
    $display("Name bytes %0d, text bytes %0d, end records ok/bad wire/mid-field %0d/%0d/%0d",
             kind_cnt[KIND_NAME], kind_cnt[KIND_TEXT], status_cnt[STATUS_OK],
             status_cnt[STATUS_BAD_WIRE], status_cnt[STATUS_MID]);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
